[rtl/core/trfa_pkg.sv]
// ----------------------------------------------------------------------------
// trfa_pkg
// Shared types, codes and constants of the tagged record frame assembler.
// ----------------------------------------------------------------------------
package trfa_pkg;

  // Default sizes
  localparam int unsigned MaxWordsDef    = 512;
  localparam int unsigned NumChannelsDef = 16;

  // Tag codes
  localparam logic [7:0] TagStatus = 8'h90;
  localparam logic [7:0] TagKey    = 8'hC0;
  localparam logic [3:0] ClsLeft   = 4'h5;
  localparam logic [3:0] ClsRight  = 4'hA;
  localparam logic [3:0] NibMarker = 4'hF;

  // Saturation limits
  localparam logic [7:0]  CntMax = 8'hFF;
  localparam logic [15:0] BadMax = 16'hFFFF;

  // Width of the per-frame wrong-length channel count
  localparam int unsigned FerrW = 5;

  // Configuration reset values
  localparam logic [7:0]  ExpLenRst   = 8'd32;
  localparam logic [3:0]  ChkChanRst  = 4'd14;
  localparam logic [31:0] SyncKeyRst  = 32'hFFBF0000;
  localparam logic        SyncInitRst = 1'b1;

  typedef enum logic [1:0] {
    CfgExpLen   = 2'd0,
    CfgChkChan  = 2'd1,
    CfgSyncKey  = 2'd2,
    CfgSyncInit = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KindData   = 3'd0,
    KindMarker = 3'd1,
    KindKey    = 3'd2,
    KindStatus = 3'd3,
    KindBad    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StExec  = 2'd1,
    StCheck = 2'd2
  } state_e;

  // Request to the channel check unit
  typedef struct packed {
    logic       start;
    logic [7:0] expected;
  } chk_ctrl_t;

  // Status of the channel check unit
  typedef struct packed {
    logic             busy;
    logic [FerrW-1:0] ferr;
  } chk_stat_t;

  // Reverse the byte order of a word
  function automatic logic [31:0] swap32(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

[rtl/core/trfa_ram.sv]
// ----------------------------------------------------------------------------
// trfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trfa_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/trfa_chk.sv]
// ----------------------------------------------------------------------------
// trfa_chk
// Frame-end channel check: walks channels 0..lim-1, one compare pair per
// channel, and counts the left and right counters that miss the expected length.
// ----------------------------------------------------------------------------
module trfa_chk #(
  parameter  int unsigned NumChannels = trfa_pkg::NumChannelsDef,
  localparam int unsigned AddrW       = $clog2(NumChannels),
  localparam int unsigned LimW        = $clog2(NumChannels + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trfa_pkg::chk_ctrl_t ctrl_i,
  input  logic [LimW-1:0]     lim_i,
  input  logic [7:0]          l_cnt_i,
  input  logic [7:0]          r_cnt_i,
  output logic [AddrW-1:0]    addr_o,
  output trfa_pkg::chk_stat_t stat_o
);
  import trfa_pkg::*;

  logic             busy_q;
  logic             phase_q;
  logic [LimW-1:0]  idx_q;
  logic [LimW-1:0]  lim_q;
  logic [7:0]       exp_q;
  logic [FerrW-1:0] ferr_q;
  logic [FerrW-1:0] mism;

  // Shared compare unit: mismatches of the current channel pair
  assign mism = FerrW'(l_cnt_i != exp_q) + FerrW'(r_cnt_i != exp_q);

  // Step the channel index: read phase, then compare phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      idx_q   <= '0;
      lim_q   <= '0;
      exp_q   <= '0;
      ferr_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q  <= 1'b1;
      phase_q <= 1'b0;
      idx_q   <= '0;
      lim_q   <= lim_i;
      exp_q   <= ctrl_i.expected;
      ferr_q  <= '0;
    end else if (busy_q) begin
      if (!phase_q) begin
        if (idx_q == lim_q) begin
          busy_q <= 1'b0;
        end else begin
          phase_q <= 1'b1;
        end
      end else begin
        ferr_q  <= ferr_q + mism;
        idx_q   <= idx_q + LimW'(1);
        phase_q <= 1'b0;
      end
    end
  end

  assign addr_o      = idx_q[AddrW-1:0];
  assign stat_o.busy = busy_q;
  assign stat_o.ferr = ferr_q;

  chk_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= lim_q)
    else $error("check index ran past its limit");

  chk_ferr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && phase_q |=> ferr_q <= $past(ferr_q) + FerrW'(2))
    else $error("check count grew by more than one channel pair");

endmodule

[rtl/core/tagged_record_frame_assembler.sv]
// ----------------------------------------------------------------------------
// tagged_record_frame_assembler
// Decodes tagged 5-byte records, keeps per-channel and per-side frame counters,
// checks marker sequence numbers and reports a frame once both end markers
// have been seen.
//
//   channel  handshake                kind     payload
//   in       in_valid_i / in_ready_o  record   tag_i, payload_i, chunk_start_i
//   out      out_valid_o / out_ready_i result  kind_o .. bad_tag_total_o
//   cfg      cfg_we_i                 write    cfg_idx_i, cfg_wdata_i
//
// A record is accepted in StIdle, which also reads its channel counter, and
// in StExec updates state and loads the output register.
// A record that completes a frame then waits in StCheck while the check unit
// reads both counter RAMs once per channel, for min(checked_channels, NumChannels) channels.
// in_ready_o is high only between records; a full output register holds
// a kept record in StExec until out_ready_i frees it.
// Reset loads the configuration defaults and clears the frame at once
// through per-entry valid bits. sync_initial takes effect at reset only,
// where its reset value applies.
// ----------------------------------------------------------------------------
module tagged_record_frame_assembler #(
  parameter  int unsigned MaxWords    = trfa_pkg::MaxWordsDef,
  parameter  int unsigned NumChannels = trfa_pkg::NumChannelsDef,
  localparam int unsigned WcW         = $clog2(MaxWords + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [31:0]                cfg_wdata_i,
  // Input records
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 tag_i,
  input  logic [31:0]                payload_i,
  input  logic                       chunk_start_i,
  // Results
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 kind_o,
  output logic                       side_o,
  output logic [3:0]                 channel_o,
  output logic [31:0]                word_o,
  output logic                       stored_o,
  output logic                       seq_error_o,
  output logic                       frame_done_o,
  output logic [trfa_pkg::FerrW-1:0] frame_chan_errors_o,
  output logic [WcW-1:0]             left_words_o,
  output logic [WcW-1:0]             right_words_o,
  output logic                       sync_on_o,
  output logic [15:0]                bad_tag_total_o
);
  import trfa_pkg::*;

  localparam int unsigned AddrW = $clog2(NumChannels);
  localparam int unsigned LimW  = $clog2(NumChannels + 1);

  state_e state_q, state_d;

  // Configuration registers
  logic [7:0]  exp_len_q;
  logic [3:0]  chk_chan_q;
  logic [31:0] sync_key_q;

  // Captured record
  logic [7:0]  tag_q;
  logic [31:0] pay_q;
  logic        start_q;

  // Frame state
  logic [NumChannels-1:0] lvalid_q, rvalid_q;
  logic [WcW-1:0]         lwc_q, rwc_q;
  logic                   lend_q, rend_q;
  logic [31:0]            lprev_q, rprev_q;
  logic                   sync_q, disc_q;
  logic [15:0]            bad_q;
  logic [AddrW-1:0]       rd_addr_q;

  // Output register
  logic             out_valid_q;
  kind_e            out_kind_q;
  logic             out_side_q;
  logic [3:0]       out_chan_q;
  logic [31:0]      out_word_q;
  logic             out_stored_q;
  logic             out_seq_q;
  logic             out_done_q;
  logic [FerrW-1:0] out_ferr_q;
  logic [WcW-1:0]   out_lw_q, out_rw_q;
  logic             out_sync_q;
  logic [15:0]      out_bad_q;

  // Decode and next values
  logic [3:0]       cls, nib;
  logic             is_status, is_key, is_side, right, is_mark, is_data, is_bad;
  logic             drop, in_range, chan_inc, wc_inc, frame_end;
  logic             out_free, commit, upd, fin;
  logic [7:0]       l_rdata, r_rdata, l_eff, r_eff, cnt_sel;
  logic [WcW-1:0]   wc_sel, lwc_next, rwc_next;
  logic             lend_next, rend_next, sync_next, seq_err;
  logic [31:0]      prev_sel, swapped;
  logic [15:0]      bad_next;
  kind_e            kind;
  logic             l_we, r_we;
  logic [AddrW-1:0] ram_addr, chk_addr;
  logic [31:0]      lim_full;
  logic [LimW-1:0]  lim;
  chk_ctrl_t        chk_ctrl;
  chk_stat_t        chk_stat;

  // Record decode
  assign cls       = tag_q[7:4];
  assign nib       = tag_q[3:0];
  assign is_status = (tag_q == TagStatus);
  assign is_key    = (tag_q == TagKey);
  assign is_side   = (cls == ClsLeft) || (cls == ClsRight);
  assign right     = (cls == ClsRight);
  assign is_mark   = is_side && (nib == NibMarker);
  assign is_data   = is_side && (nib != NibMarker);
  assign is_bad    = !is_status && !is_key && !is_side;
  assign drop      = disc_q && !start_q;

  // Counter values; an entry not yet written since the frame cleared reads zero
  assign l_eff   = lvalid_q[rd_addr_q] ? l_rdata : '0;
  assign r_eff   = rvalid_q[rd_addr_q] ? r_rdata : '0;
  assign cnt_sel = right ? r_eff : l_eff;

  assign in_range = (32'(nib) < NumChannels);
  assign chan_inc = is_data && in_range && (cnt_sel != CntMax);

  // Per-side word counts saturate at MaxWords
  assign wc_sel   = right ? rwc_q : lwc_q;
  assign wc_inc   = is_data && (wc_sel < WcW'(MaxWords));
  assign lwc_next = lwc_q + WcW'(wc_inc && !right);
  assign rwc_next = rwc_q + WcW'(wc_inc && right);

  // End markers and sequence check
  assign swapped   = swap32(pay_q);
  assign prev_sel  = right ? rprev_q : lprev_q;
  assign seq_err   = is_mark && ((prev_sel + 32'd1) != swapped);
  assign lend_next = lend_q || (is_mark && !right);
  assign rend_next = rend_q || (is_mark && right);
  assign frame_end = !is_bad && lend_next && rend_next;

  assign sync_next = sync_q ^ (is_key && (pay_q == sync_key_q));
  assign bad_next  = (is_bad && (bad_q != BadMax)) ? bad_q + 16'd1 : bad_q;

  always_comb begin
    if (is_status) begin
      kind = KindStatus;
    end else if (is_key) begin
      kind = KindKey;
    end else if (is_mark) begin
      kind = KindMarker;
    end else if (is_data) begin
      kind = KindData;
    end else begin
      kind = KindBad;
    end
  end

  // Sequencer handshakes
  assign out_free = !out_valid_q || out_ready_i;
  assign commit   = (state_q == StExec) && (drop || out_free);
  assign upd      = commit && !drop;
  assign fin      = (state_q == StCheck) && !chk_stat.busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StExec;
      end
      StExec: begin
        if (commit) state_d = (upd && frame_end) ? StCheck : StIdle;
      end
      StCheck: begin
        if (fin) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q  <= ExpLenRst;
      chk_chan_q <= ChkChanRst;
      sync_key_q <= SyncKeyRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgExpLen:   exp_len_q  <= cfg_wdata_i[7:0];
        CfgChkChan:  chk_chan_q <= cfg_wdata_i[3:0];
        CfgSyncKey:  sync_key_q <= cfg_wdata_i;
        // Sync state reloads its reset value at reset; nothing to hold
        CfgSyncInit: ;
      endcase
    end
  end

  // Capture the accepted record
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tag_q   <= tag_i;
      pay_q   <= payload_i;
      start_q <= chunk_start_i;
    end
  end

  // Counter RAM address: incoming tag, held tag, or check index
  always_comb begin
    unique case (state_q)
      StExec:  ram_addr = nib[AddrW-1:0];
      StCheck: ram_addr = chk_addr;
      default: ram_addr = tag_i[AddrW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= ram_addr;
  end

  assign l_we = upd && chan_inc && !right;
  assign r_we = upd && chan_inc && right;

  trfa_ram #(
    .Width (8),
    .Depth (NumChannels)
  ) u_left_cnt (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (nib[AddrW-1:0]),
    .wdata_i (cnt_sel + 8'd1),
    .raddr_i (ram_addr),
    .rdata_o (l_rdata)
  );

  trfa_ram #(
    .Width (8),
    .Depth (NumChannels)
  ) u_right_cnt (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (nib[AddrW-1:0]),
    .wdata_i (cnt_sel + 8'd1),
    .raddr_i (ram_addr),
    .rdata_o (r_rdata)
  );

  // Frame-end channel check
  assign lim_full          = (32'(chk_chan_q) > NumChannels) ? NumChannels : 32'(chk_chan_q);
  assign lim               = lim_full[LimW-1:0];
  assign chk_ctrl.start    = upd && frame_end;
  assign chk_ctrl.expected = exp_len_q;

  trfa_chk #(
    .NumChannels (NumChannels)
  ) u_chk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (chk_ctrl),
    .lim_i   (lim),
    .l_cnt_i (l_eff),
    .r_cnt_i (r_eff),
    .addr_o  (chk_addr),
    .stat_o  (chk_stat)
  );

  // Frame state: update on a kept record, clear on bad tag or frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvalid_q <= '0;
      rvalid_q <= '0;
      lwc_q    <= '0;
      rwc_q    <= '0;
      lend_q   <= 1'b0;
      rend_q   <= 1'b0;
      lprev_q  <= '0;
      rprev_q  <= '0;
      sync_q   <= SyncInitRst;
      disc_q   <= 1'b0;
      bad_q    <= '0;
    end else begin
      if (commit && start_q) begin
        disc_q <= 1'b0;
      end
      if (upd) begin
        bad_q  <= bad_next;
        sync_q <= sync_next;
        if (is_bad) begin
          lvalid_q <= '0;
          rvalid_q <= '0;
          lwc_q    <= '0;
          rwc_q    <= '0;
          lend_q   <= 1'b0;
          rend_q   <= 1'b0;
          disc_q   <= 1'b1;
        end else begin
          if (l_we) lvalid_q[nib[AddrW-1:0]] <= 1'b1;
          if (r_we) rvalid_q[nib[AddrW-1:0]] <= 1'b1;
          lwc_q  <= lwc_next;
          rwc_q  <= rwc_next;
          lend_q <= lend_next;
          rend_q <= rend_next;
          if (is_mark && !right) lprev_q <= swapped;
          if (is_mark && right)  rprev_q <= swapped;
        end
      end
      if (fin) begin
        lvalid_q <= '0;
        rvalid_q <= '0;
        lwc_q    <= '0;
        rwc_q    <= '0;
        lend_q   <= 1'b0;
        rend_q   <= 1'b0;
      end
    end
  end

  // Output register valid: set on a plain result or a finished check
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (upd && !frame_end)          out_valid_q <= 1'b1;
      if (fin)                        out_valid_q <= 1'b1;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (upd) begin
      out_kind_q   <= kind;
      out_side_q   <= is_side && right;
      out_chan_q   <= is_data ? nib : 4'd0;
      out_word_q   <= (is_mark || is_status) ? swapped : pay_q;
      out_stored_q <= wc_inc;
      out_seq_q    <= seq_err;
      out_done_q   <= frame_end;
      out_ferr_q   <= '0;
      out_lw_q     <= is_bad ? '0 : lwc_next;
      out_rw_q     <= is_bad ? '0 : rwc_next;
      out_sync_q   <= sync_next;
      out_bad_q    <= bad_next;
    end
    if (fin) begin
      out_ferr_q <= chk_stat.ferr;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign kind_o              = out_kind_q;
  assign side_o              = out_side_q;
  assign channel_o           = out_chan_q;
  assign word_o              = out_word_q;
  assign stored_o            = out_stored_q;
  assign seq_error_o         = out_seq_q;
  assign frame_done_o        = out_done_q;
  assign frame_chan_errors_o = out_ferr_q;
  assign left_words_o        = out_lw_q;
  assign right_words_o       = out_rw_q;
  assign sync_on_o           = out_sync_q;
  assign bad_tag_total_o     = out_bad_q;

  a_ferr_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> frame_chan_errors_o == '0)
    else $error("wrong-length count reported without a finished frame");

  a_no_write_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_stat.busy |-> !l_we && !r_we)
    else $error("counter RAM written during frame check");

  a_bad_clears_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindBad |-> left_words_o == '0 && right_words_o == '0)
    else $error("bad tag result carries word counts");

  a_check_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_ctrl.start |=> chk_stat.busy && state_q == StCheck)
    else $error("frame check did not start");

  a_wc_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lwc_q <= WcW'(MaxWords) && rwc_q <= WcW'(MaxWords))
    else $error("word count past its limit");

endmodule

[dv/trfa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfa_checker
// Watches the record, result and configuration ports of the frame assembler,
// predicts the result of every accepted record and compares each accepted
// result field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module trfa_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [31:0]                cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [7:0]                 tag_i,
  input  logic [31:0]                payload_i,
  input  logic                       chunk_start_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [2:0]                 kind_i,
  input  logic                       side_i,
  input  logic [3:0]                 channel_i,
  input  logic [31:0]                word_i,
  input  logic                       stored_i,
  input  logic                       seq_error_i,
  input  logic                       frame_done_i,
  input  logic [trfa_pkg::FerrW-1:0] frame_chan_errors_i,
  input  logic [9:0]                 left_words_i,
  input  logic [9:0]                 right_words_i,
  input  logic                       sync_on_i,
  input  logic [15:0]                bad_tag_total_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import trfa_pkg::*;

  localparam int unsigned NumChan   = NumChannelsDef;
  localparam int unsigned WordLimit = MaxWordsDef;

  typedef struct {
    kind_e            kind;
    logic             side;
    logic [3:0]       channel;
    logic [31:0]      word;
    logic             stored;
    logic             seq_error;
    logic             frame_done;
    logic [FerrW-1:0] chan_errors;
    logic [9:0]       left_words;
    logic [9:0]       right_words;
    logic             sync_on;
    logic [15:0]      bad_total;
  } record_result_t;

  // Configuration copy
  logic [7:0]  exp_len;
  logic [3:0]  chk_chan;
  logic [31:0] key_word;

  // Frame state, indexed by side (0 left, 1 right)
  logic [7:0]  chan_cnt [2][NumChan];
  logic [9:0]  word_cnt [2];
  logic        end_seen [2];
  logic [31:0] prev_cnt [2];
  logic        sync_st;
  logic        dropping;
  logic [15:0] bad_cnt;

  record_result_t awaited_results [$];
  int             mismatches;

  function automatic logic [31:0] byte_reverse(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  task automatic clear_frame();
    for (int s = 0; s < 2; s++) begin
      for (int c = 0; c < NumChan; c++) chan_cnt[s][c] = '0;
      word_cnt[s] = '0;
      end_seen[s] = 1'b0;
    end
  endtask

  // Predict the result of one accepted record and queue it
  task automatic assemble_record(input logic [7:0] tag, input logic [31:0] pl,
                                 input logic start);
    record_result_t r;
    logic [3:0]     cls;
    logic [3:0]     nib;
    logic           sd;
    cls           = tag[7:4];
    nib           = tag[3:0];
    sd            = (cls == ClsRight);
    r.kind        = KindData;
    r.side        = 1'b0;
    r.channel     = '0;
    r.word        = pl;
    r.stored      = 1'b0;
    r.seq_error   = 1'b0;
    r.frame_done  = 1'b0;
    r.chan_errors = '0;
    if (start) dropping = 1'b0;
    if (dropping) return;

    if (tag == TagStatus) begin
      r.kind = KindStatus;
      r.word = byte_reverse(pl);
    end else if (tag == TagKey) begin
      r.kind = KindKey;
      if (pl == key_word) sync_st = !sync_st;
    end else if (cls == ClsLeft || cls == ClsRight) begin
      r.side = sd;
      if (nib == NibMarker) begin
        r.kind      = KindMarker;
        r.word      = byte_reverse(pl);
        r.seq_error = (prev_cnt[sd] + 32'd1) != r.word;
        prev_cnt[sd] = r.word;
        end_seen[sd] = 1'b1;
      end else begin
        r.channel = nib;
        if (chan_cnt[sd][nib] != CntMax) chan_cnt[sd][nib]++;
        if (word_cnt[sd] < WordLimit) begin
          word_cnt[sd]++;
          r.stored = 1'b1;
        end
      end
    end else begin
      r.kind = KindBad;
      if (bad_cnt != BadMax) bad_cnt++;
      clear_frame();
      dropping = 1'b1;
    end

    r.left_words  = word_cnt[0];
    r.right_words = word_cnt[1];

    // Close the frame once both end markers are in
    if (r.kind != KindBad && end_seen[0] && end_seen[1]) begin
      for (int i = 0; i < int'(chk_chan); i++) begin
        if (chan_cnt[0][i] != exp_len) r.chan_errors++;
        if (chan_cnt[1][i] != exp_len) r.chan_errors++;
      end
      r.frame_done = 1'b1;
      clear_frame();
    end

    r.sync_on   = sync_st;
    r.bad_total = bad_cnt;
    awaited_results.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare one accepted result against the oldest prediction
  task automatic match_result();
    record_result_t r;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d word %0h",
               $time, kind_i, word_i);
      mismatches++;
      return;
    end
    r = awaited_results.pop_front();
    compare_field("kind", 32'(r.kind), 32'(kind_i));
    compare_field("side", 32'(r.side), 32'(side_i));
    compare_field("channel", 32'(r.channel), 32'(channel_i));
    compare_field("word", r.word, word_i);
    compare_field("stored", 32'(r.stored), 32'(stored_i));
    compare_field("seq_error", 32'(r.seq_error), 32'(seq_error_i));
    compare_field("frame_done", 32'(r.frame_done), 32'(frame_done_i));
    compare_field("frame_chan_errors", 32'(r.chan_errors), 32'(frame_chan_errors_i));
    compare_field("left_words", 32'(r.left_words), 32'(left_words_i));
    compare_field("right_words", 32'(r.right_words), 32'(right_words_i));
    compare_field("sync_on", 32'(r.sync_on), 32'(sync_on_i));
    compare_field("bad_tag_total", 32'(r.bad_total), 32'(bad_tag_total_i));
  endtask

  // Sample every transaction at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len  = ExpLenRst;
      chk_chan = ChkChanRst;
      key_word = SyncKeyRst;
      clear_frame();
      prev_cnt[0] = '0;
      prev_cnt[1] = '0;
      sync_st     = SyncInitRst;
      dropping    = 1'b0;
      bad_cnt     = '0;
      awaited_results.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) match_result();
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgExpLen:   exp_len  = cfg_wdata_i[7:0];
          CfgChkChan:  chk_chan = cfg_wdata_i[3:0];
          CfgSyncKey:  key_word = cfg_wdata_i;
          // sync_initial only loads at reset, and reset comes once
          CfgSyncInit: ;
          default:     ;
        endcase
      end
      if (in_valid_i && in_ready_i) assemble_record(tag_i, payload_i, chunk_start_i);
      fail_count_o <= mismatches;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tagged records through the frame assembler: a directed pass over
// each tag class and corner, then random frames, noise and broken chunks
// under several register settings, and a back-to-back burst of unknown tags.
// The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import trfa_pkg::*;

  localparam int SettleCycles = 64;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = CfgExpLen;
  logic [31:0] cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [7:0]  tag_i         = '0;
  logic [31:0] payload_i     = '0;
  logic        chunk_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [2:0]  kind_o;
  logic        side_o;
  logic [3:0]  channel_o;
  logic [31:0] word_o;
  logic        stored_o;
  logic        seq_error_o;
  logic        frame_done_o;
  logic [FerrW-1:0] frame_chan_errors_o;
  logic [9:0]  left_words_o;
  logic [9:0]  right_words_o;
  logic        sync_on_o;
  logic [15:0] bad_tag_total_o;

  int          fail_count;
  int          pending_results;
  int          sent_items = 0;
  int          rx_wait    = 0;
  bit          tx_idle    = 1'b1;
  bit          rx_idle    = 1'b1;
  logic [7:0]  cur_exp    = ExpLenRst;
  logic [31:0] cur_key    = SyncKeyRst;
  logic [31:0] side_seq [2] = '{32'd0, 32'd0};

  always #2 clk_i = ~clk_i;

  tagged_record_frame_assembler uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .tag_i               (tag_i),
    .payload_i           (payload_i),
    .chunk_start_i       (chunk_start_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .kind_o              (kind_o),
    .side_o              (side_o),
    .channel_o           (channel_o),
    .word_o              (word_o),
    .stored_o            (stored_o),
    .seq_error_o         (seq_error_o),
    .frame_done_o        (frame_done_o),
    .frame_chan_errors_o (frame_chan_errors_o),
    .left_words_o        (left_words_o),
    .right_words_o       (right_words_o),
    .sync_on_o           (sync_on_o),
    .bad_tag_total_o     (bad_tag_total_o)
  );

  trfa_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .tag_i               (tag_i),
    .payload_i           (payload_i),
    .chunk_start_i       (chunk_start_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .kind_i              (kind_o),
    .side_i              (side_o),
    .channel_i           (channel_o),
    .word_i              (word_o),
    .stored_i            (stored_o),
    .seq_error_i         (seq_error_o),
    .frame_done_i        (frame_done_o),
    .frame_chan_errors_i (frame_chan_errors_o),
    .left_words_i        (left_words_o),
    .right_words_i       (right_words_o),
    .sync_on_i           (sync_on_o),
    .bad_tag_total_i     (bad_tag_total_o),
    .fail_count_o        (fail_count),
    .pending_o           (pending_results)
  );

  function automatic int draw_gap(bit en);
    return en ? int'($urandom_range(0, 18)) : 0;
  endfunction

  // Any tag outside the status, key and left/right classes
  function automatic logic [7:0] pick_bad_tag();
    logic [7:0] t;
    do t = 8'($urandom);
    while (t == TagStatus || t == TagKey || t[7:4] == ClsLeft || t[7:4] == ClsRight);
    return t;
  endfunction

  // Result side: stall a random number of cycles after each transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait = 0;
    end else if (out_valid_o && out_ready_i) begin
      rx_wait = draw_gap(rx_idle);
      out_ready_i <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      out_ready_i <= (rx_wait == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Offer one record and hold it until the transaction completes
  task automatic send_record(input logic [7:0] tag, input logic [31:0] word,
                             input logic start);
    int gap;
    gap = draw_gap(tx_idle);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    tag_i         <= tag;
    payload_i     <= word;
    chunk_start_i <= start;
    do @(posedge clk_i);
    while (!in_ready_o);
    sent_items++;
  endtask

  // Stop sending, wait for every predicted result, then let the block settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i);
    while (pending_results != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all four registers; unused upper data bits carry junk
  task automatic load_config(input logic [7:0] exp_len, input logic [3:0] chk,
                             input logic [31:0] key, input logic sync_init);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgExpLen;
    cfg_wdata_i <= {24'($urandom), exp_len};
    @(posedge clk_i);
    cfg_idx_i   <= CfgChkChan;
    cfg_wdata_i <= {28'($urandom), chk};
    @(posedge clk_i);
    cfg_idx_i   <= CfgSyncKey;
    cfg_wdata_i <= key;
    @(posedge clk_i);
    cfg_idx_i   <= CfgSyncInit;
    cfg_wdata_i <= {31'($urandom), sync_init};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_exp = exp_len;
    cur_key = key;
  endtask

  // One frame: shuffled channel data on both sides, then the end markers
  task automatic send_frame(input bit bulk);
    logic [7:0]  tags [$];
    logic [7:0]  t;
    logic [31:0] cnt;
    int          n;
    int          k;
    bit          exact;
    bit          first_right;
    bit          repeat_first;
    bit          s;
    exact = (cur_exp <= 4) && ($urandom_range(0, 2) != 0);
    // bulk: push one side past the word limit and one channel past 255
    if (bulk) begin
      repeat (260) tags.push_back({ClsLeft, 4'd2});
      repeat (260) tags.push_back({ClsLeft, 4'($urandom_range(0, 14))});
    end
    for (int sd = 0; sd < 2; sd++) begin
      for (int c = 0; c < 15; c++) begin
        n = exact ? int'(cur_exp) : int'($urandom_range(0, 3));
        repeat (n) tags.push_back({((sd == 1) ? ClsRight : ClsLeft), 4'(c)});
      end
    end
    for (int j = tags.size() - 1; j > 0; j--) begin
      k       = $urandom_range(0, j);
      t       = tags[j];
      tags[j] = tags[k];
      tags[k] = t;
    end
    foreach (tags[j]) begin
      // sprinkle status, key and the odd bad tag into the data
      case ($urandom_range(0, 39))
        0: send_record(TagStatus, $urandom, 1'b0);
        1: send_record(TagKey, ($urandom_range(0, 1) != 0) ? cur_key : $urandom, 1'b0);
        2: send_record(pick_bad_tag(), $urandom, 1'b0);
        default: ;
      endcase
      send_record(tags[j], $urandom, ($urandom_range(0, 15) == 0));
    end
    first_right  = 1'($urandom_range(0, 1));
    repeat_first = ($urandom_range(0, 7) == 0);
    for (int m = 0; m < 3; m++) begin
      if (m == 1 && !repeat_first) continue;
      s   = (m == 2) ? !first_right : first_right;
      cnt = ($urandom_range(0, 9) != 0) ? side_seq[s] + 32'd1 : $urandom;
      side_seq[s] = cnt;
      send_record({(s ? ClsRight : ClsLeft), NibMarker},
                  {cnt[7:0], cnt[15:8], cnt[23:16], cnt[31:24]}, 1'b0);
    end
  endtask

  // Mostly well-formed frames, with noise, broken chunks and pauses
  task automatic random_traffic(input int target);
    int stop_at;
    int pick;
    stop_at = sent_items + target;
    while (sent_items < stop_at) begin
      tx_idle <= ($urandom_range(0, 3) != 0);
      rx_idle <= ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(1'b0);
      end else if (pick < 80) begin
        send_record(8'($urandom), $urandom, 1'($urandom));
      end else if (pick < 90) begin
        send_record(pick_bad_tag(), $urandom, 1'($urandom));
        repeat ($urandom_range(0, 4)) send_record(8'($urandom), $urandom, 1'b0);
        send_record(TagStatus, $urandom, 1'b1);
      end else if (pick < 97) begin
        send_record(TagKey, ($urandom_range(0, 1) != 0) ? cur_key : $urandom,
                    1'($urandom));
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass under the reset configuration
    send_record(TagStatus, 32'h1234_5678, 1'b1);
    send_record(TagKey, SyncKeyRst, 1'b0);
    send_record(TagKey, 32'h0000_0000, 1'b0);
    send_record({ClsLeft, 4'h0}, 32'h0000_0000, 1'b0);
    send_record({ClsLeft, 4'hE}, 32'hFFFF_FFFF, 1'b0);
    send_record({ClsRight, 4'h0}, 32'hA5A5_5A5A, 1'b0);
    send_record({ClsRight, 4'hE}, 32'h5A5A_A5A5, 1'b1);
    send_record({ClsLeft, NibMarker}, 32'h0100_0000, 1'b0);
    // repeated left marker, then a right marker with a bad sequence
    send_record({ClsLeft, NibMarker}, 32'h0200_0000, 1'b0);
    send_record({ClsRight, NibMarker}, 32'hFFFF_FFFF, 1'b0);
    // counter wraps from all ones to zero
    send_record({ClsRight, NibMarker}, 32'h0000_0000, 1'b0);
    // unknown tag, then records dropped until the next chunk start
    send_record(8'h00, 32'hAAAA_5555, 1'b0);
    send_record(TagStatus, 32'h0BAD_F00D, 1'b0);
    send_record({ClsLeft, NibMarker}, 32'h0300_0000, 1'b0);
    send_record(8'hFF, 32'hFFFF_FFFF, 1'b0);
    send_record({ClsLeft, 4'h1}, 32'h1111_1111, 1'b1);
    send_record(8'hFF, 32'h0000_0000, 1'b1);
    send_record(pick_bad_tag(), 32'h8000_0001, 1'b1);
    send_record({ClsRight, 4'h5}, 32'h7FFF_FFFE, 1'b1);
    send_record(TagKey, SyncKeyRst, 1'b0);
    send_record({ClsLeft, NibMarker}, 32'h0400_0000, 1'b0);
    send_record({ClsRight, NibMarker}, 32'h0100_0000, 1'b0);
    send_record(TagStatus | 8'h01, 32'h0000_0001, 1'b1);
    send_record(TagKey | 8'h01, 32'h8000_0000, 1'b1);
    drain_results();

    // Low extremes
    load_config(8'd0, 4'd0, 32'h0000_0000, 1'b0);
    random_traffic(250);
    drain_results();

    // High extremes, with one oversized frame for saturation
    load_config(8'd255, 4'd15, 32'hFFFF_FFFF, 1'b1);
    send_frame(1'b1);
    random_traffic(200);
    drain_results();

    // Random setting with short expected lengths
    load_config(8'($urandom_range(1, 3)), 4'($urandom_range(1, 15)), $urandom,
                1'($urandom));
    random_traffic(300);
    drain_results();

    load_config(8'd2, 4'd15, SyncKeyRst, 1'b0);
    random_traffic(250);
    drain_results();

    // Burst of unknown tags, each on a fresh chunk, with no idle cycles
    tx_idle <= 1'b0;
    rx_idle <= 1'b0;
    repeat (32) send_record(pick_bad_tag(), $urandom, 1'b1);
    drain_results();

    if (fail_count == 0 && pending_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
